// File: rtl/assert_macros.svh
// Assertion macros shared by the RTL of the escape decoder.
// Included by name; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_ALWAYS(lbl, clk, rst_n, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("assertion failed");
`define ASSERT_IMPLY(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define ASSERT_ALWAYS(lbl, clk, rst_n, expr)
`define ASSERT_IMPLY(lbl, clk, rst_n, ante, cons)
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

// File: rtl/esd_pkg.sv
// Types, character codes and helper functions of the escape decoder.
// No dependencies.
package esd_pkg;

    localparam int CHAR_BITS = 16;

    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_IDX_W = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

    typedef logic [CHAR_BITS-1:0] t_char;
    typedef logic [2:0]           t_digits;

    typedef enum logic [3:0] {
        MODE_NORMAL  = 4'b0001,
        MODE_ESCAPE  = 4'b0010,
        MODE_HEX     = 4'b0100,
        MODE_STOPPED = 4'b1000
    } t_mode;

    typedef struct packed {
        t_char char_out;
        logic  char_valid;
        logic  end_of_string;
    } t_result;

    typedef struct packed {
        logic       is_hex;
        logic [3:0] value;
    } t_hex_digit;

    localparam t_char CH_NUL       = '0;
    localparam t_char CH_BACKSLASH = t_char'(8'h5C);
    localparam t_char CH_LOWER_R   = t_char'(8'h72);
    localparam t_char CH_LOWER_N   = t_char'(8'h6E);
    localparam t_char CH_LOWER_T   = t_char'(8'h74);
    localparam t_char CH_LOWER_V   = t_char'(8'h76);
    localparam t_char CH_LOWER_F   = t_char'(8'h66);
    localparam t_char CH_LOWER_X   = t_char'(8'h78);
    localparam t_char CH_LOWER_U   = t_char'(8'h75);
    localparam t_char CH_DIGIT_0   = t_char'(8'h30);
    localparam t_char CH_DIGIT_9   = t_char'(8'h39);
    localparam t_char CH_LOWER_A   = t_char'(8'h61);
    localparam t_char CH_UPPER_A   = t_char'(8'h41);
    localparam t_char CH_UPPER_F   = t_char'(8'h46);

    localparam t_char CC_CR = t_char'(8'd13);
    localparam t_char CC_LF = t_char'(8'd10);
    localparam t_char CC_HT = t_char'(8'd9);
    localparam t_char CC_VT = t_char'(8'd11);
    localparam t_char CC_FF = t_char'(8'd12);

    localparam t_digits HEX_DIGITS_X = 3'd2;
    localparam t_digits HEX_DIGITS_U = 3'd4;

    function automatic t_hex_digit hex_digit(input t_char c);
        t_hex_digit d;
        t_char      off;
        d   = '0;
        off = '0;
        if (c inside {[CH_DIGIT_0:CH_DIGIT_9]}) begin
            off = c - CH_DIGIT_0;
            d   = '{is_hex: 1'b1, value: off[3:0]};
        end else if (c inside {[CH_LOWER_A:CH_LOWER_F]}) begin
            off = c - CH_LOWER_A + t_char'(4'd10);
            d   = '{is_hex: 1'b1, value: off[3:0]};
        end else if (c inside {[CH_UPPER_A:CH_UPPER_F]}) begin
            off = c - CH_UPPER_A + t_char'(4'd10);
            d   = '{is_hex: 1'b1, value: off[3:0]};
        end
        return d;
    endfunction

endpackage

// File: rtl/escape_sequence_decoder_unit.sv
// Escape decoder: one code unit per transaction in, up to two decoded units out.
// The input stage registers each item; decoded results go into the result queue, whose head drives the output port.
// Throughput: one input per cycle; an item that yields two results is drained one result per
//   output transfer, absorbed by a 4-entry result queue before the input stalls.
// Reset (i_rst_n low, synchronous): queue and input stage emptied, decode state normal.
// Depends on esd_pkg and assert_macros.svh.
`include "assert_macros.svh"

module escape_sequence_decoder_unit (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    output logic                         o_in_stall,
    input  logic [esd_pkg::CHAR_BITS-1:0] i_char_in,
    input  logic                         i_last_char,
    output logic                         o_out_valid,
    input  logic                         i_out_stall,
    output logic [esd_pkg::CHAR_BITS-1:0] o_char_out,
    output logic                         o_char_valid,
    output logic                         o_end_of_string
);

    // input stage
    logic                r_s1_valid;
    esd_pkg::t_char      r_s1_char;
    logic                r_s1_last;

    // decode state
    esd_pkg::t_mode      r_mode,      n_mode;
    esd_pkg::t_char      r_hex_value, n_hex_value;
    esd_pkg::t_digits    r_hex_left,  n_hex_left;

    // result queue
    esd_pkg::t_result                  r_queue [esd_pkg::QUEUE_DEPTH];
    logic [esd_pkg::QUEUE_IDX_W-1:0]   r_head, r_tail;
    logic [esd_pkg::QUEUE_CNT_W-1:0]   r_count;

    esd_pkg::t_result    res [2];
    logic [1:0]          res_cnt;
    logic                fire;
    logic                pop;
    logic                accept;
    esd_pkg::t_hex_digit dig;
    esd_pkg::t_char      hex_shift;
    esd_pkg::t_digits    left_dec;

    // room for two results before an item is decoded
    assign fire       = r_s1_valid && (r_count <= esd_pkg::QUEUE_CNT_W'(esd_pkg::QUEUE_DEPTH - 2));
    assign o_in_stall = r_s1_valid && !fire;
    assign accept     = i_in_valid && !o_in_stall;
    assign pop        = (r_count != '0) && !i_out_stall;

    assign dig       = esd_pkg::hex_digit(r_s1_char);
    assign hex_shift = {r_hex_value[esd_pkg::CHAR_BITS-5:0], dig.value};
    assign left_dec  = r_hex_left - 3'd1;

    always_comb begin
        logic do_normal;
        do_normal   = 1'b0;
        n_mode      = r_mode;
        n_hex_value = r_hex_value;
        n_hex_left  = r_hex_left;
        res[0]      = '0;
        res[1]      = '0;
        res_cnt     = 2'd0;

        case (r_mode)
            esd_pkg::MODE_NORMAL: begin
                do_normal = 1'b1;
            end
            esd_pkg::MODE_ESCAPE: begin
                n_mode = esd_pkg::MODE_NORMAL;
                case (r_s1_char)
                    esd_pkg::CH_LOWER_R: begin
                        res[res_cnt[0]] = '{esd_pkg::CC_CR, 1'b1, 1'b0};
                        res_cnt = res_cnt + 2'd1;
                    end
                    esd_pkg::CH_LOWER_N: begin
                        res[res_cnt[0]] = '{esd_pkg::CC_LF, 1'b1, 1'b0};
                        res_cnt = res_cnt + 2'd1;
                    end
                    esd_pkg::CH_LOWER_T: begin
                        res[res_cnt[0]] = '{esd_pkg::CC_HT, 1'b1, 1'b0};
                        res_cnt = res_cnt + 2'd1;
                    end
                    esd_pkg::CH_LOWER_V: begin
                        res[res_cnt[0]] = '{esd_pkg::CC_VT, 1'b1, 1'b0};
                        res_cnt = res_cnt + 2'd1;
                    end
                    esd_pkg::CH_LOWER_F: begin
                        res[res_cnt[0]] = '{esd_pkg::CC_FF, 1'b1, 1'b0};
                        res_cnt = res_cnt + 2'd1;
                    end
                    esd_pkg::CH_LOWER_X: begin
                        n_mode      = esd_pkg::MODE_HEX;
                        n_hex_value = '0;
                        n_hex_left  = esd_pkg::HEX_DIGITS_X;
                    end
                    esd_pkg::CH_LOWER_U: begin
                        n_mode      = esd_pkg::MODE_HEX;
                        n_hex_value = '0;
                        n_hex_left  = esd_pkg::HEX_DIGITS_U;
                    end
                    default: begin
                        res[res_cnt[0]] = '{r_s1_char, 1'b1, 1'b0};
                        res_cnt = res_cnt + 2'd1;
                    end
                endcase
            end
            esd_pkg::MODE_HEX: begin
                if (dig.is_hex && (r_hex_left != '0)) begin
                    n_hex_value = hex_shift;
                    n_hex_left  = left_dec;
                    if (left_dec == '0) begin
                        n_mode          = esd_pkg::MODE_NORMAL;
                        res[res_cnt[0]] = '{hex_shift, 1'b1, 1'b0};
                        res_cnt         = res_cnt + 2'd1;
                        n_hex_value     = '0;
                    end
                end else begin
                    // flush the value, then decode the terminator as in normal mode
                    res[res_cnt[0]] = '{r_hex_value, 1'b1, 1'b0};
                    res_cnt         = res_cnt + 2'd1;
                    n_hex_value     = '0;
                    n_hex_left      = '0;
                    n_mode          = esd_pkg::MODE_NORMAL;
                    do_normal       = 1'b1;
                end
            end
            default: begin
            end
        endcase

        if (do_normal) begin
            if (r_s1_char == esd_pkg::CH_NUL) begin
                n_mode = esd_pkg::MODE_STOPPED;
            end else if (r_s1_char == esd_pkg::CH_BACKSLASH) begin
                n_mode = esd_pkg::MODE_ESCAPE;
            end else begin
                res[res_cnt[0]] = '{r_s1_char, 1'b1, 1'b0};
                res_cnt         = res_cnt + 2'd1;
            end
        end

        if (r_s1_last) begin
            if (n_mode == esd_pkg::MODE_HEX) begin
                res[res_cnt[0]] = '{n_hex_value, 1'b1, 1'b0};
                res_cnt         = res_cnt + 2'd1;
            end
            if (res_cnt == 2'd0) begin
                res[0]  = '{'0, 1'b0, 1'b0};
                res_cnt = 2'd1;
            end
            // mark the final result of the string
            res[~res_cnt[0]].end_of_string = 1'b1;
            n_mode      = esd_pkg::MODE_NORMAL;
            n_hex_value = '0;
            n_hex_left  = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_mode      <= esd_pkg::MODE_NORMAL;
            r_hex_value <= '0;
            r_hex_left  <= '0;
            r_head      <= '0;
            r_tail      <= '0;
            r_count     <= '0;
        end else begin
            if (accept) begin
                r_s1_valid <= 1'b1;
            end else if (fire) begin
                r_s1_valid <= 1'b0;
            end
            if (fire) begin
                r_mode      <= n_mode;
                r_hex_value <= n_hex_value;
                r_hex_left  <= n_hex_left;
                r_tail      <= r_tail + esd_pkg::QUEUE_IDX_W'(res_cnt);
            end
            if (pop) begin
                r_head <= r_head + esd_pkg::QUEUE_IDX_W'(1);
            end
            r_count <= r_count
                     + (fire ? esd_pkg::QUEUE_CNT_W'(res_cnt) : '0)
                     - esd_pkg::QUEUE_CNT_W'(pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_char <= i_char_in;
            r_s1_last <= i_last_char;
        end
        if (fire && (res_cnt != 2'd0)) begin
            r_queue[r_tail] <= res[0];
        end
        if (fire && (res_cnt == 2'd2)) begin
            r_queue[r_tail + esd_pkg::QUEUE_IDX_W'(1)] <= res[1];
        end
    end

    assign o_out_valid     = (r_count != '0);
    assign o_char_out      = r_queue[r_head].char_out;
    assign o_char_valid    = r_queue[r_head].char_valid;
    assign o_end_of_string = r_queue[r_head].end_of_string;

    `ASSERT_ALWAYS(a_queue_bound, i_clk, i_rst_n, r_count <= esd_pkg::QUEUE_CNT_W'(esd_pkg::QUEUE_DEPTH))
    `ASSERT_IMPLY(a_hex_left_match, i_clk, i_rst_n, r_mode == esd_pkg::MODE_HEX, r_hex_left != '0)
    `ASSERT_IMPLY(a_idle_no_digits, i_clk, i_rst_n, r_mode != esd_pkg::MODE_HEX, r_hex_left == '0)
    `ASSERT_IMPLY(a_last_yields, i_clk, i_rst_n, fire && r_s1_last, res_cnt != 2'd0)
    `ASSERT_NEXT(a_last_resets, i_clk, i_rst_n, fire && r_s1_last, r_mode == esd_pkg::MODE_NORMAL && r_hex_value == '0)

endmodule
